@@ hw/rtl/sample_history_ring_buffer_defines.svh @@
// Assertion macros used by the sample history ring buffer RTL.
`ifndef SAMPLE_HISTORY_RING_BUFFER_DEFINES_SVH
`define SAMPLE_HISTORY_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SHRB_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SHRB_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

@@ hw/rtl/shrb_pkg.sv @@
// Shared constants, types and helper functions of the sample history ring buffer.
package shrb_pkg;

   localparam int BUFFER_BYTES     = 4096;
   localparam int MAX_SAMPLE_BYTES = 8;

   localparam int ADDR_W  = $clog2(BUFFER_BYTES);
   localparam int SLOT_W  = ADDR_W;
   localparam int CAP_W   = SLOT_W + 1;
   localparam int SIZE_W  = 4;
   localparam int BIDX_W  = 3;
   localparam int COUNT_W = 12;
   localparam int BACK_W  = 12;
   localparam int DATA_W  = 64;
   localparam int CMP_W   = (CAP_W > BACK_W + 1) ? CAP_W : BACK_W + 1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_SIZE = CSR_ADDR_W'(0);

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DATA_W-1:0] sample_data;
      logic [BACK_W-1:0] samples_back;
      logic              hold_position;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               all_read;
      logic [COUNT_W-1:0] sample_count;
      logic               history_full;
   } rsp_payload_type;

   typedef struct packed {
      logic [SIZE_W-1:0] sample_size;
      logic [CAP_W-1:0]  slot_capacity;
      logic              clear_pointers;
   } cfg_type;

   // Slots that fit in the store for a given sample size.
   function automatic logic [CAP_W-1:0] capacity_of(input logic [SIZE_W-1:0] size);
      logic [CAP_W-1:0] cap;
      case (size)
         4'd2:    cap = CAP_W'(BUFFER_BYTES / 2);
         4'd3:    cap = CAP_W'(BUFFER_BYTES / 3);
         4'd4:    cap = CAP_W'(BUFFER_BYTES / 4);
         4'd5:    cap = CAP_W'(BUFFER_BYTES / 5);
         4'd6:    cap = CAP_W'(BUFFER_BYTES / 6);
         4'd7:    cap = CAP_W'(BUFFER_BYTES / 7);
         4'd8:    cap = CAP_W'(BUFFER_BYTES / 8);
         default: cap = CAP_W'(BUFFER_BYTES / 1);
      endcase
      return cap;
   endfunction

endpackage

@@ hw/rtl/sample_history_ring_buffer.sv @@
// Top level of the sample history ring buffer: sequencer, byte store and result register.
//
// Overwrite-oldest history of samples of 1 to 8 bytes, kept in a byte-wide
// synchronous store of BUFFER_BYTES with one access per cycle. Requests are
// taken one at a time: a put passes the put state (one byte written per
// cycle) and the finish state, a read-next the read state (one byte read per
// cycle), the last-read state for the store's registered read data and the
// finish state, and a readout start or an unknown request only the finish state.
// The byte port of the store sets this pacing. The result sits in an output
// register, so a new request is accepted while the previous result still
// waits to be taken. Writing the sample size register clears head, tail and
// readout pointers; do so only while the block is idle. The store needs no
// clearing pass: reading a slot never written returns undefined data.
`include "sample_history_ring_buffer_defines.svh"

module sample_history_ring_buffer
   import shrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PUT    = 5'b00010,
      ST_READ   = 5'b00100,
      ST_RDLAST = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   cfg_type cfg;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [SLOT_W-1:0]   rdp_ff, rdp_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [BIDX_W-1:0]   idx_ff, idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [BIDX_W-1:0]   rd_idx_ff;
   logic [DATA_W-1:0]   acc_ff;
   logic [DATA_W-1:0]   data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff;

   logic [7:0]          mem [BUFFER_BYTES];
   logic [7:0]          mem_rdata_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;
   logic [7:0]          mem_wdata;

   logic                req_accept;
   logic                last_byte;
   logic                out_free;
   logic                finish_load;
   logic [SLOT_W-1:0]   mul_slot;
   logic [SLOT_W+SIZE_W-1:0] mul_prod;
   logic [CAP_W-1:0]    held_now;
   logic [CAP_W-1:0]    held_fin;
   logic                full_now;
   logic [CMP_W-1:0]    back_ext;
   logic [CMP_W-1:0]    head_ext;
   logic [CMP_W-1:0]    wrap_sum;

   // Slot after the given one, wrapping at the capacity.
   function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] slot,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] n;
      n = {1'b0, slot} + CAP_W'(1);
      return (n >= cap) ? '0 : n[SLOT_W-1:0];
   endfunction

   // Samples held between tail and head.
   function automatic logic [CAP_W-1:0] held(input logic [SLOT_W-1:0] head,
                                             input logic [SLOT_W-1:0] tail,
                                             input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] h;
      logic [CAP_W-1:0] t;
      h = {1'b0, head};
      t = {1'b0, tail};
      return (h >= t) ? (h - t) : (cap - (t - h));
   endfunction

   shrb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Take a new request only from idle; the result register decouples the output.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign last_byte   = ({1'b0, idx_ff} == (cfg.sample_size - SIZE_W'(1)));
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign finish_load = (state_ff == ST_FINISH) && out_free;

   // Status before the step, used to decide a put or a readout start.
   assign held_now = held(head_ff, tail_ff, cfg.slot_capacity);
   assign full_now = (advance(head_ff, cfg.slot_capacity) == tail_ff);
   assign held_fin = held_now;

   // Byte address of the first byte of the slot being touched.
   assign mul_slot = (req_payload.req_type == OP_READ) ? rdp_ff : head_ff;
   assign mul_prod = mul_slot * cfg.sample_size;

   assign back_ext = CMP_W'(req_payload.samples_back);
   assign head_ext = CMP_W'(head_ff);
   assign wrap_sum = head_ext + CMP_W'(cfg.slot_capacity) - back_ext;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      rdp_in     = rdp_ff;
      base_in    = base_ff;
      idx_in     = idx_ff;
      rd_pend_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in  = '0;
               base_in = ADDR_W'(mul_prod);
               case (req_payload.req_type)
                  OP_PUT: begin
                     // Drop the oldest sample when the ring is full.
                     if (full_now) begin
                        tail_in = advance(tail_ff, cfg.slot_capacity);
                     end
                     head_in  = advance(head_ff, cfg.slot_capacity);
                     state_in = ST_PUT;
                  end
                  OP_START: begin
                     if (CMP_W'(held_now) <= back_ext) begin
                        rdp_in = tail_ff;
                     end else if (head_ext >= back_ext) begin
                        rdp_in = SLOT_W'(head_ext - back_ext);
                     end else begin
                        rdp_in = SLOT_W'(wrap_sum);
                     end
                     state_in = ST_FINISH;
                  end
                  OP_READ: begin
                     if (!req_payload.hold_position) begin
                        rdp_in = advance(rdp_ff, cfg.slot_capacity);
                     end
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PUT: begin
            idx_in = idx_ff + BIDX_W'(1);
            if (last_byte) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            rd_pend_in = 1'b1;
            idx_in     = idx_ff + BIDX_W'(1);
            if (last_byte) begin
               state_in = ST_RDLAST;
            end
         end
         ST_RDLAST: begin
            // Last byte lands in the accumulator this cycle.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A sample size write restarts the history.
      if (cfg.clear_pointers) begin
         head_in = '0;
         tail_in = '0;
         rdp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         rdp_ff     <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         rdp_ff     <= rdp_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // Request payload and working registers.
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      rd_idx_ff <= idx_ff;
      if (req_accept) begin
         data_ff <= req_payload.sample_data;
         acc_ff  <= '0;
      end else if (rd_pend_ff) begin
         acc_ff[rd_idx_ff*8 +: 8] <= mem_rdata_ff;
      end
   end

   // Byte store: one write or one read per cycle, read data registered.
   assign mem_addr  = base_ff + ADDR_W'(idx_ff);
   assign mem_we    = (state_ff == ST_PUT);
   assign mem_wdata = data_ff[idx_ff*8 +: 8];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // Result register: load on finish, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_load) begin
         rsp_payload_ff.read_data    <= acc_ff;
         rsp_payload_ff.all_read     <= (rdp_ff == head_ff);
         rsp_payload_ff.sample_count <= COUNT_W'(held_fin);
         rsp_payload_ff.history_full <= full_now;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Every accepted put that does not meet a pointer clear moves the head.
   `SHRB_ASSERT_NEXT(a_put_moves_head, clock, reset,
      req_accept && (req_payload.req_type == OP_PUT) && !cfg.clear_pointers,
      head_ff != $past(head_ff))

   // Pointers stay inside the ring.
   `SHRB_ASSERT_SAME(a_ptr_in_range, clock, reset, 1'b1,
      ({1'b0, head_ff} < cfg.slot_capacity) && ({1'b0, tail_ff} < cfg.slot_capacity) &&
      ({1'b0, rdp_ff} < cfg.slot_capacity))

   // A new result appears only after the finish state.
   `SHRB_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_FINISH))

   // The store is written only while no request can be accepted.
   `SHRB_ASSERT_SAME(a_store_busy, clock, reset, mem_we, req_stall && !rd_pend_ff)

endmodule

@@ hw/rtl/shrb_csr.sv @@
// Configuration register block: sample size, slot capacity and pointer clear.
module shrb_csr
   import shrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic [SIZE_W-1:0] wr_size;
   logic              wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == REG_SAMPLE_SIZE);

   // Saturate the written size into 1..MAX_SAMPLE_BYTES.
   always_comb begin
      wr_size = csr_pwdata[SIZE_W-1:0];
      if (wr_size == '0) begin
         wr_size = SIZE_W'(1);
      end else if (wr_size > SIZE_W'(MAX_SAMPLE_BYTES)) begin
         wr_size = SIZE_W'(MAX_SAMPLE_BYTES);
      end
      size_in = wr_hit ? wr_size : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_SAMPLE_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   assign cfg.sample_size    = size_ff;
   assign cfg.slot_capacity  = capacity_of(size_ff);
   assign cfg.clear_pointers = wr_hit;

endmodule
